// ===== hw/rtl/multi_key_click_detector_assert.svh =====
// assertion macros used by the port-level checker
`ifndef MULTI_KEY_CLICK_DETECTOR_ASSERT_SVH
`define MULTI_KEY_CLICK_DETECTOR_ASSERT_SVH

// same-cycle implication, off while reset is asserted
`define MKCD_ASSERT_IMP(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
        else $error("assertion failed");

// next-cycle implication, off while reset is asserted
`define MKCD_ASSERT_NXT(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error("assertion failed");

// next-cycle implication that also holds through reset
`define MKCD_ASSERT_RST(lbl, clk, pre, post) \
    lbl: assert property (@(posedge clk) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/mkcd_pkg.sv =====
// types and constants of the multi-key click detector
`timescale 1ns / 1ps
package mkcd_pkg;

    localparam int SCAN_W  = 8;
    localparam int TIME_W  = 16;
    localparam int FLAG_W  = 7;
    localparam int LEVEL_W = 4;
    localparam int KIDX_W  = 2;
    localparam int CIDX_W  = 8;
    localparam int CDATA_W = 16;

    localparam logic [SCAN_W-1:0] SCAN_PERIOD_RST = 8'd20;
    localparam logic [TIME_W-1:0] LONG_TIME_RST   = 16'd1000;
    localparam logic [TIME_W-1:0] DCLICK_WIN_RST  = 16'd200;
    localparam logic [TIME_W-1:0] REPEAT_INT_RST  = 16'd100;

    localparam logic [FLAG_W-1:0] F_HOLD   = 7'h01;
    localparam logic [FLAG_W-1:0] F_DOWN   = 7'h02;
    localparam logic [FLAG_W-1:0] F_UP     = 7'h04;
    localparam logic [FLAG_W-1:0] F_SINGLE = 7'h08;
    localparam logic [FLAG_W-1:0] F_DOUBLE = 7'h10;
    localparam logic [FLAG_W-1:0] F_LONG   = 7'h20;
    localparam logic [FLAG_W-1:0] F_REPEAT = 7'h40;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_CHECK = 1'b1;

    localparam logic [CIDX_W-1:0] CFG_SCAN_PERIOD = 8'd0;
    localparam logic [CIDX_W-1:0] CFG_LONG_TIME   = 8'd1;
    localparam logic [CIDX_W-1:0] CFG_DCLICK_WIN  = 8'd2;
    localparam logic [CIDX_W-1:0] CFG_REPEAT_INT  = 8'd3;

    typedef enum logic [2:0] {
        CS_IDLE          = 3'd0,
        CS_FIRST_PRESS   = 3'd1,
        CS_FIRST_RELEASE = 3'd2,
        CS_SECOND_PRESS  = 3'd3,
        CS_LONG_HOLD     = 3'd4
    } click_state_t;

    typedef struct packed {
        logic               cur;
        logic               prev;
        click_state_t       state;
        logic [TIME_W-1:0]  timer;
        logic [FLAG_W-1:0]  flags;
    } key_state_t;

    localparam int KEY_W = $bits(key_state_t);

    typedef struct packed {
        logic [SCAN_W-1:0] scan_period;
        logic [TIME_W-1:0] long_time;
        logic [TIME_W-1:0] dclick_win;
        logic [TIME_W-1:0] repeat_int;
    } cfg_t;

endpackage

// ===== hw/rtl/mkcd_ram.sv =====
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module mkcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/mkcd_key_update.sv =====
// per-key timer countdown, sampling and click state machine for one tick
`timescale 1ns / 1ps
module mkcd_key_update
    import mkcd_pkg::*;
(
    input  key_state_t st_in,
    input  cfg_t       cfg,
    input  logic       sample,
    input  logic       down,
    output key_state_t st_out
);

    logic [TIME_W-1:0] timer_dec;
    logic              timer_zero;

    assign timer_dec  = (st_in.timer == '0) ? '0 : st_in.timer - TIME_W'(1);
    assign timer_zero = (timer_dec == '0);

    always_comb begin
        st_out       = st_in;
        st_out.timer = timer_dec;
        if (sample) begin
            st_out.prev = st_in.cur;
            st_out.cur  = down;
            if (down) begin
                st_out.flags = st_in.flags | F_HOLD;
            end else begin
                st_out.flags = st_in.flags & ~F_HOLD;
            end
            if (down && !st_in.cur) begin
                st_out.flags = st_out.flags | F_DOWN;
            end
            if (!down && st_in.cur) begin
                st_out.flags = st_out.flags | F_UP;
            end
            unique case (st_in.state)
                CS_FIRST_PRESS: begin
                    if (!down) begin
                        st_out.timer = cfg.dclick_win;
                        st_out.state = CS_FIRST_RELEASE;
                    end else if (timer_zero) begin
                        st_out.timer = cfg.repeat_int;
                        st_out.flags = st_out.flags | F_LONG;
                        st_out.state = CS_LONG_HOLD;
                    end
                end
                CS_FIRST_RELEASE: begin
                    if (down) begin
                        st_out.flags = st_out.flags | F_DOUBLE;
                        st_out.state = CS_SECOND_PRESS;
                    end else if (timer_zero) begin
                        st_out.flags = st_out.flags | F_SINGLE;
                        st_out.state = CS_IDLE;
                    end
                end
                CS_SECOND_PRESS: begin
                    if (!down) begin
                        st_out.state = CS_IDLE;
                    end
                end
                CS_LONG_HOLD: begin
                    if (!down) begin
                        st_out.state = CS_IDLE;
                    end else if (timer_zero) begin
                        st_out.timer = cfg.repeat_int;
                        st_out.flags = st_out.flags | F_REPEAT;
                    end
                end
                default: begin
                    st_out.state = CS_IDLE;
                    if (down) begin
                        st_out.timer = cfg.long_time;
                        st_out.state = CS_FIRST_PRESS;
                    end
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/multi_key_click_detector.sv =====
// An accepted item passes the holding stage (state row update), then the output register,
// before its result shows on m_*; one item per cycle unless m_tready stalls the output.
// All key state and the scan counter form one row of a one-entry ram that is read
// every cycle; the row written at the previous edge is forwarded over the read data.
// Reset: synchronous, active low; clears control, loads register defaults and
// drops the row valid bit so the state reads as all zero until first written.
`timescale 1ns / 1ps
module multi_key_click_detector
    import mkcd_pkg::*;
#(
    parameter int KEYS = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // pressed_levels[3:0], key_index[5:4], flag_mask[12:6]
    input  logic [0:0]  s_tuser,   // op[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // hit[0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [CIDX_W-1:0]  cfg_index,
    input  logic [CDATA_W-1:0] cfg_data
);

    localparam int ROW_W = SCAN_W + KEYS * KEY_W;

    cfg_t cfg_reg;

    logic                s1_valid_reg;
    logic                s1_op_reg;
    logic [LEVEL_W-1:0]  s1_levels_reg;
    logic [KIDX_W-1:0]   s1_key_reg;
    logic [FLAG_W-1:0]   s1_mask_reg;

    logic                m_valid_reg;
    logic                m_valid_next;
    logic                m_hit_reg;

    logic                row_valid_reg;
    logic                fwd_valid_reg;
    logic [ROW_W-1:0]    fwd_row_reg;
    logic [ROW_W-1:0]    rd_row;
    logic [ROW_W-1:0]    cur_row;
    logic [ROW_W-1:0]    new_row;

    logic                s_xfer;
    logic                s1_fire;
    logic [SCAN_W-1:0]   scan_cur;
    logic [SCAN_W-1:0]   scan_inc;
    logic                sample;
    logic                hit;

    key_state_t          key_cur  [KEYS];
    key_state_t          key_upd  [KEYS];

    assign cfg_ready = 1'b1;
    assign s_xfer    = s_tvalid && s_tready;
    assign s1_fire   = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !s1_valid_reg || s1_fire;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.scan_period <= SCAN_PERIOD_RST;
            cfg_reg.long_time   <= LONG_TIME_RST;
            cfg_reg.dclick_win  <= DCLICK_WIN_RST;
            cfg_reg.repeat_int  <= REPEAT_INT_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_SCAN_PERIOD: cfg_reg.scan_period <= cfg_data[SCAN_W-1:0];
                CFG_LONG_TIME:   cfg_reg.long_time   <= cfg_data;
                CFG_DCLICK_WIN:  cfg_reg.dclick_win  <= cfg_data;
                CFG_REPEAT_INT:  cfg_reg.repeat_int  <= cfg_data;
                default: ;
            endcase
        end
    end

    // state row storage
    mkcd_ram #(
        .WIDTH(ROW_W),
        .DEPTH(1)
    ) u_row_ram (
        .aclk  (aclk),
        .we    (s1_fire),
        .waddr (1'b0),
        .wdata (new_row),
        .raddr (1'b0),
        .rdata (rd_row)
    );

    always_comb begin
        if (fwd_valid_reg) begin
            cur_row = fwd_row_reg;
        end else if (row_valid_reg) begin
            cur_row = rd_row;
        end else begin
            cur_row = '0;
        end
    end

    assign scan_cur = cur_row[SCAN_W-1:0];
    assign scan_inc = scan_cur + SCAN_W'(1);
    assign sample   = (scan_inc >= cfg_reg.scan_period);

    for (genvar k = 0; k < KEYS; k++) begin : g_key
        logic down;
        assign key_cur[k] = key_state_t'(cur_row[SCAN_W + k * KEY_W +: KEY_W]);
        if (k < LEVEL_W) begin : g_pin
            assign down = s1_levels_reg[k];
        end else begin : g_nopin
            assign down = 1'b0;
        end
        mkcd_key_update u_upd (
            .st_in  (key_cur[k]),
            .cfg    (cfg_reg),
            .sample (sample),
            .down   (down),
            .st_out (key_upd[k])
        );
    end

    always_comb begin
        key_state_t ks;
        logic       sel;
        ks      = '0;
        sel     = 1'b0;
        hit     = 1'b0;
        new_row = cur_row;
        if (s1_op_reg == OP_TICK) begin
            new_row[SCAN_W-1:0] = sample ? '0 : scan_inc;
            for (int k = 0; k < KEYS; k++) begin
                new_row[SCAN_W + k * KEY_W +: KEY_W] = key_upd[k];
            end
        end else begin
            for (int k = 0; k < KEYS; k++) begin
                ks  = key_cur[k];
                sel = (int'(s1_key_reg) == k);
                if (sel && ((ks.flags & s1_mask_reg) != '0)) begin
                    hit = 1'b1;
                    if (s1_mask_reg != F_HOLD) begin
                        ks.flags = ks.flags & ~s1_mask_reg;
                    end
                    new_row[SCAN_W + k * KEY_W +: KEY_W] = ks;
                end
            end
        end
    end

    always_comb begin
        if (s1_fire) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            row_valid_reg <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                s1_valid_reg <= s_xfer;
            end
            m_valid_reg   <= m_valid_next;
            fwd_valid_reg <= s1_fire;
            if (s1_fire) begin
                row_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            s1_op_reg     <= s_tuser[0];
            s1_levels_reg <= s_tdata[3:0];
            s1_key_reg    <= s_tdata[5:4];
            s1_mask_reg   <= s_tdata[12:6];
        end
        if (s1_fire) begin
            fwd_row_reg <= new_row;
            m_hit_reg   <= hit;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, m_hit_reg};

endmodule

// ===== hw/rtl/mkcd_checker.sv =====
// port-level checker for the multi-key click detector, bound to the top level
`timescale 1ns / 1ps
`include "multi_key_click_detector_assert.svh"
module mkcd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // a stalled result holds its value
    `MKCD_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // input side only blocks while a result waits at the output
    `MKCD_ASSERT_IMP(a_back_pressure, aclk, aresetn, !s_tready, m_tvalid && !m_tready)

    // unused result bits stay zero
    `MKCD_ASSERT_IMP(a_pad_zero, aclk, aresetn, m_tvalid, m_tdata[7:1] == 7'b0)

    // reset empties the output
    `MKCD_ASSERT_RST(a_reset_empty, aclk, !aresetn, !m_tvalid)

endmodule

bind multi_key_click_detector mkcd_checker u_mkcd_checker (.*);
